[rtl/core/lav_pkg.sv]
// shared constants and types for the look-at view matrix builder
package lav_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DW = 32;                   // input and output word
  localparam int AW = FRAC_BITS + 2;        // normalized component, holds +-1.0
  localparam int PW = DW + AW;              // word times unit product
  localparam int NV_W = PW + 1;             // raw cross product component
  localparam int MW = 31;                   // magnitude after prescale
  localparam int SW = 2 * MW + 2;           // sum of three squares
  localparam int RW = SW / 2;               // integer root
  localparam int KW = $clog2(NV_W - MW + 1);
  localparam int QW = FRAC_BITS + 1;        // quotient bits, at most 1.0
  localparam int OSW = PW + 2;              // dot product sum

  // axis codes, in emission order
  localparam logic [1:0] AXIS_RIGHT = 2'd0;
  localparam logic [1:0] AXIS_UP    = 2'd1;
  localparam logic [1:0] AXIS_LOOK  = 2'd2;

  typedef logic signed [DW-1:0]   word_t;
  typedef logic signed [AW-1:0]   unit_t;
  typedef logic signed [NV_W-1:0] raw_t;

  // data that rides along the pipeline beside the vector under work
  typedef struct packed {
    word_t [2:0] pos;
    word_t [2:0] rgt;
    unit_t [2:0] lk;
    unit_t [2:0] up;
  } side_t;

endpackage

[rtl/core/lav_norm.sv]
// pipelined vector normalizer: prescale, sum of squares, root, divide
module lav_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  lav_pkg::raw_t [2:0]  in_vec,
  input  lav_pkg::side_t       in_side,
  output logic                 out_valid,
  output lav_pkg::unit_t [2:0] out_vec,
  output lav_pkg::side_t       out_side
);
  import lav_pkg::*;

  typedef struct packed {
    logic [RW:0]            rem;
    logic [RW-1:0]          root;
    logic [SW-1:0]          rad;
    logic [2:0][MW-1:0]     m;
    logic [2:0]             neg;
    side_t                  side;
  } sq_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] q;
    logic [2:0]         lsb;
    logic [RW-1:0]      n;
    logic [2:0]         neg;
    side_t              side;
  } dv_t;

  // magnitudes and prescale shift search
  logic [NV_W-1:0] mag_c [3];
  logic [NV_W-1:0] or_c;
  logic [KW-1:0]   k_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][NV_W-1] ? NV_W'(~in_vec[i]) + NV_W'(1) : NV_W'(in_vec[i]);
    end
    or_c = mag_c[0] | mag_c[1] | mag_c[2];
    k_c = '0;
    for (int b = MW; b < NV_W; b++) begin
      if (or_c[b]) k_c = KW'(b - MW + 1);
    end
  end

  logic                a_valid;
  logic [NV_W-1:0]     a_mag [3];
  logic [KW-1:0]       a_k;
  logic [2:0]          a_neg;
  side_t               a_side;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= mag_c[i];
        a_neg[i] <= in_vec[i][NV_W-1];
      end
      a_k <= k_c;
      a_side <= in_side;
    end
  end

  // apply prescale shift
  logic               b_valid;
  logic [2:0][MW-1:0] b_m;
  logic [2:0]         b_neg;
  side_t              b_side;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) b_m[i] <= MW'(a_mag[i] >> a_k);
      b_neg <= a_neg;
      b_side <= a_side;
    end
  end

  // squares
  logic               c_valid;
  logic [2*MW-1:0]    c_sq [3];
  logic [2:0][MW-1:0] c_m;
  logic [2:0]         c_neg;
  side_t              c_side;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_sq[i] <= (2*MW)'(b_m[i]) * (2*MW)'(b_m[i]);
      c_m <= b_m;
      c_neg <= b_neg;
      c_side <= b_side;
    end
  end

  // sum of squares
  logic               d_valid;
  logic [SW-1:0]      d_s;
  logic [2:0][MW-1:0] d_m;
  logic [2:0]         d_neg;
  side_t              d_side;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s <= SW'(c_sq[0]) + SW'(c_sq[1]) + SW'(c_sq[2]);
      d_m <= c_m;
      d_neg <= c_neg;
      d_side <= c_side;
    end
  end

  // integer square root, one result bit per stage
  sq_t  sq   [RW];
  logic sq_v [RW];
  sq_t  sq_start;

  always_comb begin
    sq_start.rem  = '0;
    sq_start.root = '0;
    sq_start.rad  = d_s;
    sq_start.m    = d_m;
    sq_start.neg  = d_neg;
    sq_start.side = d_side;
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    sq_t           src;
    logic          src_v;
    sq_t           nxt;
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;

    if (j == 0) begin : g_first
      assign src = sq_start;
      assign src_v = d_valid;
    end else begin : g_rest
      assign src = sq[j-1];
      assign src_v = sq_v[j-1];
    end

    always_comb begin
      nxt = src;
      cur = {src.rem, src.rad[SW-1:SW-2]};
      trial = {1'b0, src.root, 2'b01};
      nxt.rad = src.rad << 2;
      if (cur >= trial) begin
        nxt.rem  = (RW+1)'(cur - trial);
        nxt.root = {src.root[RW-2:0], 1'b1};
      end else begin
        nxt.rem  = cur[RW:0];
        nxt.root = {src.root[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[j] <= 1'b0;
      else if (en) sq_v[j] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) sq[j] <= nxt;
    end
  end

  // restoring division of each scaled magnitude by the root
  dv_t  dv   [QW];
  logic dv_v [QW];
  dv_t  dv_start;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_start.rem[i] = RW'(sq[RW-1].m[i] >> 1);
      dv_start.lsb[i] = sq[RW-1].m[i][0];
    end
    dv_start.q    = '0;
    dv_start.n    = sq[RW-1].root;
    dv_start.neg  = sq[RW-1].neg;
    dv_start.side = sq[RW-1].side;
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    dv_t         src;
    logic        src_v;
    dv_t         nxt;
    logic [RW:0] cur [3];

    if (t == 0) begin : g_first
      assign src = dv_start;
      assign src_v = sq_v[RW-1];
    end else begin : g_rest
      assign src = dv[t-1];
      assign src_v = dv_v[t-1];
    end

    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        cur[i] = {src.rem[i], (t == 0) ? src.lsb[i] : 1'b0};
        if (cur[i] >= {1'b0, src.n}) begin
          nxt.rem[i] = RW'(cur[i] - {1'b0, src.n});
          nxt.q[i]   = {src.q[i][QW-2:0], 1'b1};
        end else begin
          nxt.rem[i] = cur[i][RW-1:0];
          nxt.q[i]   = {src.q[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[t] <= 1'b0;
      else if (en) dv_v[t] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (en) dv[t] <= nxt;
    end
  end

  // sign and zero-length handling
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv[QW-1].n == '0) out_vec[i] <= '0;
        else if (dv[QW-1].neg[i]) out_vec[i] <= -AW'(dv[QW-1].q[i]);
        else out_vec[i] <= AW'(dv[QW-1].q[i]);
      end
      out_side <= dv[QW-1].side;
    end
  end

endmodule

[rtl/core/lav_cross.sv]
// two-stage cross product of a unit vector with a word vector
module lav_cross (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  lav_pkg::unit_t [2:0] a,
  input  lav_pkg::word_t [2:0] b,
  input  lav_pkg::side_t       in_side,
  output logic                 out_valid,
  output lav_pkg::raw_t [2:0]  out_vec,
  output lav_pkg::side_t       out_side
);
  import lav_pkg::*;

  logic                 p_valid;
  logic signed [PW-1:0] p [6];
  side_t                p_side;

  // partial products
  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= PW'($signed(a[1])) * PW'($signed(b[2]));
      p[1] <= PW'($signed(a[2])) * PW'($signed(b[1]));
      p[2] <= PW'($signed(a[2])) * PW'($signed(b[0]));
      p[3] <= PW'($signed(a[0])) * PW'($signed(b[2]));
      p[4] <= PW'($signed(a[0])) * PW'($signed(b[1]));
      p[5] <= PW'($signed(a[1])) * PW'($signed(b[0]));
      p_side <= in_side;
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec[0] <= NV_W'(p[0]) - NV_W'(p[1]);
      out_vec[1] <= NV_W'(p[2]) - NV_W'(p[3]);
      out_vec[2] <= NV_W'(p[4]) - NV_W'(p[5]);
      out_side <= p_side;
    end
  end

endmodule

[rtl/core/lav_offset.sv]
// translation terms: negated position dotted with each axis, saturated
module lav_offset (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  lav_pkg::word_t [2:0]      pos,
  input  lav_pkg::unit_t [2:0][2:0] ax,
  output logic                      out_valid,
  output lav_pkg::unit_t [2:0][2:0] out_ax,
  output lav_pkg::word_t [2:0]      out_off
);
  import lav_pkg::*;

  logic                  p_valid;
  logic signed [PW-1:0]  p [3][3];
  unit_t [2:0][2:0]      p_ax;

  // nine products
  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          p[k][i] <= PW'($signed(pos[i])) * PW'($signed(ax[k][i]));
        end
      end
      p_ax <= ax;
    end
  end

  // dot sums
  logic                  s_valid;
  logic signed [OSW-1:0] s [3];
  unit_t [2:0][2:0]      s_ax;

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (en) s_valid <= p_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s[k] <= OSW'(p[k][0]) + OSW'(p[k][1]) + OSW'(p[k][2]);
      end
      s_ax <= p_ax;
    end
  end

  // negate, floor shift, saturate
  logic signed [OSW-1:0] sh [3];

  always_comb begin
    for (int k = 0; k < 3; k++) sh[k] = (-s[k]) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (sh[k][OSW-1:DW-1] == '0 || sh[k][OSW-1:DW-1] == '1) begin
          out_off[k] <= sh[k][DW-1:0];
        end else if (sh[k][OSW-1]) begin
          out_off[k] <= {1'b1, {(DW-1){1'b0}}};
        end else begin
          out_off[k] <= {1'b0, {(DW-1){1'b1}}};
        end
      end
      out_ax <= s_ax;
    end
  end

endmodule

[rtl/core/look_at_view_matrix_builder.sv]
// look-at view matrix builder; an item may enter every cycle while in_stall is low, but the
// single result port sends the right, up and look rows one per cycle while out_stall is low,
// so the result register loads the next item only as the look row of the last one goes out
// the whole pipeline holds while a finished item waits for the busy result register
// synchronous active-high reset clears all valid bits; data registers are not reset
module look_at_view_matrix_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lav_pkg::word_t      pos_x,
  input  lav_pkg::word_t      pos_y,
  input  lav_pkg::word_t      pos_z,
  input  lav_pkg::word_t      right_x,
  input  lav_pkg::word_t      right_y,
  input  lav_pkg::word_t      right_z,
  input  lav_pkg::word_t      look_x,
  input  lav_pkg::word_t      look_y,
  input  lav_pkg::word_t      look_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          axis_sel,
  output lav_pkg::word_t      comp_x,
  output lav_pkg::word_t      comp_y,
  output lav_pkg::word_t      comp_z,
  output lav_pkg::word_t      offset,
  output logic                last
);
  import lav_pkg::*;

  logic en;

  // look normalizer input
  raw_t [2:0] lk_raw;
  side_t      side0;

  always_comb begin
    lk_raw[0] = NV_W'(look_x);
    lk_raw[1] = NV_W'(look_y);
    lk_raw[2] = NV_W'(look_z);
    side0.pos = {pos_z, pos_y, pos_x};
    side0.rgt = {right_z, right_y, right_x};
    side0.lk  = '0;
    side0.up  = '0;
  end

  logic        n1_v;
  unit_t [2:0] look_n;
  side_t       n1_side;

  lav_norm u_norm_look (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .in_vec(lk_raw), .in_side(side0),
    .out_valid(n1_v), .out_vec(look_n), .out_side(n1_side)
  );

  // up = look x right
  side_t side1;

  always_comb begin
    side1 = n1_side;
    side1.lk = look_n;
  end

  logic       c1_v;
  raw_t [2:0] up_raw;
  side_t      c1_side;

  lav_cross u_cross_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(n1_v),
    .a(look_n), .b(side1.rgt), .in_side(side1),
    .out_valid(c1_v), .out_vec(up_raw), .out_side(c1_side)
  );

  logic        n2_v;
  unit_t [2:0] up_n;
  side_t       n2_side;

  lav_norm u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(c1_v),
    .in_vec(up_raw), .in_side(c1_side),
    .out_valid(n2_v), .out_vec(up_n), .out_side(n2_side)
  );

  // right = up x look
  side_t       side2;
  word_t [2:0] look_w;

  always_comb begin
    side2 = n2_side;
    side2.up = up_n;
    for (int i = 0; i < 3; i++) look_w[i] = DW'($signed(n2_side.lk[i]));
  end

  logic       c2_v;
  raw_t [2:0] rt_raw;
  side_t      c2_side;

  lav_cross u_cross_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(n2_v),
    .a(up_n), .b(look_w), .in_side(side2),
    .out_valid(c2_v), .out_vec(rt_raw), .out_side(c2_side)
  );

  logic        n3_v;
  unit_t [2:0] rt_n;
  side_t       n3_side;

  lav_norm u_norm_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(c2_v),
    .in_vec(rt_raw), .in_side(c2_side),
    .out_valid(n3_v), .out_vec(rt_n), .out_side(n3_side)
  );

  // translation per axis
  unit_t [2:0][2:0] axes;

  always_comb begin
    axes[AXIS_RIGHT] = rt_n;
    axes[AXIS_UP]    = n3_side.up;
    axes[AXIS_LOOK]  = n3_side.lk;
  end

  logic             off_v;
  unit_t [2:0][2:0] off_ax;
  word_t [2:0]      off_val;

  lav_offset u_offset (
    .clk(clk), .rst(rst), .en(en), .in_valid(n3_v),
    .pos(n3_side.pos), .ax(axes),
    .out_valid(off_v), .out_ax(off_ax), .out_off(off_val)
  );

  // result register, sends three rows per item
  logic             ser_v;
  logic [1:0]       ser_idx;
  unit_t [2:0][2:0] ser_ax;
  word_t [2:0]      ser_off;
  logic             ser_load_ok;
  logic             load;

  assign ser_load_ok = !ser_v || (ser_idx == AXIS_LOOK && !out_stall);
  assign en = !off_v || ser_load_ok;
  assign load = en && off_v;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      ser_idx <= AXIS_RIGHT;
    end else if (load) begin
      ser_v <= 1'b1;
      ser_idx <= AXIS_RIGHT;
    end else if (ser_v && !out_stall) begin
      if (ser_idx == AXIS_LOOK) ser_v <= 1'b0;
      else ser_idx <= ser_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_ax <= off_ax;
      ser_off <= off_val;
    end
  end

  // result fields
  assign out_valid = ser_v;
  assign axis_sel  = ser_idx;
  assign comp_x    = DW'($signed(ser_ax[ser_idx][0]));
  assign comp_y    = DW'($signed(ser_ax[ser_idx][1]));
  assign comp_z    = DW'($signed(ser_ax[ser_idx][2]));
  assign offset    = ser_off[ser_idx];
  assign last      = (ser_idx == AXIS_LOOK);

endmodule

[dv/look_at_view_matrix_checker.sv]
// checker for the look-at view matrix builder: predicts the three axis rows and compares
`timescale 1ns / 1ps

module look_at_view_matrix_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  lav_pkg::word_t pos_x,
  input  lav_pkg::word_t pos_y,
  input  lav_pkg::word_t pos_z,
  input  lav_pkg::word_t right_x,
  input  lav_pkg::word_t right_y,
  input  lav_pkg::word_t right_z,
  input  lav_pkg::word_t look_x,
  input  lav_pkg::word_t look_y,
  input  lav_pkg::word_t look_z,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [1:0]     axis_sel,
  input  lav_pkg::word_t comp_x,
  input  lav_pkg::word_t comp_y,
  input  lav_pkg::word_t comp_z,
  input  lav_pkg::word_t offset,
  input  logic           last,
  output int             fail_count,
  output int             rows_pending
);
  import lav_pkg::*;

  typedef struct {
    logic [1:0] axis;
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      off;
    logic       last;
  } axis_row_t;

  typedef longint vec3_t [3];

  axis_row_t rows_due[$];

  assign rows_pending = rows_due.size();

  // floor square root, bit by bit
  function automatic logic [63:0] floor_root(input logic [63:0] s);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = s;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // unit vector: prescale magnitudes below 2^31, divide by the integer root
  function automatic vec3_t unitize(input vec3_t v);
    logic [63:0] m [3];
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] r;
    vec3_t o;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
    while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    n = floor_root(s);
    for (int i = 0; i < 3; i++) begin
      r = (n != 0) ? (m[i] << FRAC_BITS) / n : 64'd0;
      o[i] = v[i] < 0 ? -longint'(r) : longint'(r);
    end
    return o;
  endfunction

  function automatic vec3_t cross_prod(input vec3_t a, input vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  // translation: floor of the negated dot product, saturated to a word
  function automatic word_t translation(input vec3_t p, input vec3_t ax);
    longint d;
    longint q;
    d = -(p[0] * ax[0] + p[1] * ax[1] + p[2] * ax[2]);
    q = d >>> FRAC_BITS;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return word_t'(q);
  endfunction

  // queue the right, up and look rows for one input transfer
  task automatic predict_rows();
    vec3_t p, rg, lk, look_u, up_u, right_u;
    vec3_t axes [3];
    axis_row_t row;
    p  = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
    rg = '{longint'(right_x), longint'(right_y), longint'(right_z)};
    lk = '{longint'(look_x), longint'(look_y), longint'(look_z)};
    look_u  = unitize(lk);
    up_u    = unitize(cross_prod(look_u, rg));
    right_u = unitize(cross_prod(up_u, look_u));
    axes[0] = right_u;
    axes[1] = up_u;
    axes[2] = look_u;
    for (int k = 0; k < 3; k++) begin
      row.axis = (k == 0) ? AXIS_RIGHT : (k == 1) ? AXIS_UP : AXIS_LOOK;
      row.x    = word_t'(axes[k][0]);
      row.y    = word_t'(axes[k][1]);
      row.z    = word_t'(axes[k][2]);
      row.off  = translation(p, axes[k]);
      row.last = (k == 2);
      rows_due.push_back(row);
    end
  endtask

  task automatic compare_row();
    axis_row_t e;
    if (rows_due.size() == 0) begin
      $error("result transfer with no row expected");
      fail_count++;
      return;
    end
    e = rows_due.pop_front();
    if (axis_sel !== e.axis) begin
      $error("axis_sel: expected %0d, got %0d", e.axis, axis_sel); fail_count++;
    end
    if (comp_x !== e.x) begin
      $error("comp_x: expected %0d, got %0d", e.x, comp_x); fail_count++;
    end
    if (comp_y !== e.y) begin
      $error("comp_y: expected %0d, got %0d", e.y, comp_y); fail_count++;
    end
    if (comp_z !== e.z) begin
      $error("comp_z: expected %0d, got %0d", e.z, comp_z); fail_count++;
    end
    if (offset !== e.off) begin
      $error("offset: expected %0d, got %0d", e.off, offset); fail_count++;
    end
    if (last !== e.last) begin
      $error("last: expected %0b, got %0b", e.last, last); fail_count++;
    end
  endtask

  initial fail_count = 0;

  // watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) predict_rows();
      if (out_valid && !out_stall) compare_row();
    end
  end

endmodule

[dv/look_at_view_matrix_builder_tb.sv]
// testbench top for the look-at view matrix builder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module look_at_view_matrix_builder_tb;
  import lav_pkg::*;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t ONE   = 32'sh0001_0000;

  logic  clk = 0;
  logic  rst = 1;
  logic  in_valid = 0;
  logic  in_stall;
  word_t pos_x = 0, pos_y = 0, pos_z = 0;
  word_t right_x = 0, right_y = 0, right_z = 0;
  word_t look_x = 0, look_y = 0, look_z = 0;
  logic  out_valid;
  logic  out_stall = 0;
  logic [1:0] axis_sel;
  word_t comp_x, comp_y, comp_z, offset;
  logic  last;
  int    fail_count;
  int    rows_pending;
  logic  no_idle = 0;

  look_at_view_matrix_builder uut (.*);

  look_at_view_matrix_checker chk (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver stalls at random unless in a quiet stretch
  always @(posedge clk) out_stall <= !no_idle && ($urandom_range(99) < 31);

  initial begin
    #5ms;
    $display("look_at_view_matrix_builder_tb: errors");
    $finish;
  end

  function automatic word_t pick_word();
    case ($urandom_range(5))
      0: return W_MAX;
      1: return W_MIN;
      2: return word_t'($urandom_range(2 * 65536 * 4)) - 4 * 65536;
      3: return $urandom_range(1) ? ONE : -ONE;
      4: return 0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // one transfer; in_valid stays high unless the sender takes a gap
  task automatic send(input word_t p[3], input word_t r[3], input word_t l[3]);
    int gap;
    if (!no_idle && $urandom_range(99) < 31) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    right_x <= r[0]; right_y <= r[1]; right_z <= r[2];
    look_x <= l[0]; look_y <= l[1]; look_z <= l[2];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    word_t p[3], r[3], l[3];
    for (int i = 0; i < 3; i++) begin
      p[i] = $urandom_range(2) == 0 ? word_t'($urandom) : pick_word();
      r[i] = $urandom_range(2) == 0 ? word_t'($urandom) : pick_word();
      l[i] = $urandom_range(2) == 0 ? word_t'($urandom) : pick_word();
    end
    // look parallel to right now and then
    if ($urandom_range(19) == 0) l = r;
    send(p, r, l);
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: identity frame, zero look, look parallel to right, extremes
    send('{0, 0, 0}, '{ONE, 0, 0}, '{0, 0, ONE});
    send('{ONE, 2 * ONE, -3 * ONE}, '{ONE, 0, 0}, '{0, 0, ONE});
    send('{ONE, ONE, ONE}, '{ONE, 0, 0}, '{0, 0, 0});
    send('{ONE, ONE, ONE}, '{ONE, ONE, 0}, '{2 * ONE, 2 * ONE, 0});
    send('{W_MAX, W_MAX, W_MAX}, '{ONE, -ONE, 0}, '{ONE, ONE, ONE});
    send('{W_MIN, W_MIN, W_MIN}, '{ONE, -ONE, 0}, '{ONE, ONE, ONE});
    send('{W_MAX, W_MIN, W_MAX}, '{W_MIN, W_MAX, W_MIN}, '{W_MIN, W_MIN, W_MIN});
    send('{W_MIN, W_MAX, 0}, '{W_MAX, W_MAX, W_MAX}, '{W_MAX, 0, W_MIN});
    send('{-1, -1, -1}, '{0, 0, 1}, '{1, 0, 0});
    send('{1, 1, 1}, '{-1, -1, -1}, '{0, -1, 0});
    send('{-ONE, 3, -7}, '{0, ONE, 0}, '{-ONE, 0, 0});
    send('{32'sh0000_8000, -32'sh0000_8000, 1}, '{ONE, ONE, ONE}, '{-1, 1, 0});
    send('{W_MAX, 0, 0}, '{0, W_MIN, 0}, '{0, 0, W_MAX});
    send('{0, 0, 0}, '{W_MAX, W_MAX, W_MAX}, '{W_MAX, W_MAX, W_MAX});

    // hold off until every row has drained
    in_valid <= 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    for (int n = 0; n < 400; n++) begin
      no_idle = (n >= 150 && n < 230);
      send_random();
    end
    no_idle = 0;
    in_valid <= 0;

    waited = 0;
    while (rows_pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0)
      $display("look_at_view_matrix_builder_tb: clean");
    else
      $display("look_at_view_matrix_builder_tb: errors");
    $finish;
  end

endmodule
